/* rtl/vn2d_pkg.sv */
// Shared constants for the 2D vector normalizer.
package vn2d_pkg;
  localparam int UNIT_FRAC = 30;              // fraction bits of the unit components
  localparam int QUO_W     = UNIT_FRAC + 1;   // quotient bits, up to 2^30 inclusive
  localparam int OUT_W     = 32;              // width of the magnitude, cosine and sine fields
endpackage

/* rtl/vn2d_sqrt_cell.sv */
// One step of the pipelined integer square root: retires one root bit.
module vn2d_sqrt_cell #(
  parameter int W     = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2*W-1:0]   in_rad,
  input  logic [W+1:0]     in_rem,
  input  logic [W-1:0]     in_root,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [2*W-1:0]   out_rad,
  output logic [W+1:0]     out_rem,
  output logic [W-1:0]     out_root,
  output logic [TAG_W-1:0] out_tag
);
  logic [W+1:0] rem_sh;
  logic [W+1:0] trial;
  logic         fits;

  always_comb begin
    rem_sh = {in_rem[W-1:0], in_rad[2*W-1 -: 2]};
    trial  = {in_root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rad  <= {in_rad[2*W-3:0], 2'b00};
    out_rem  <= fits ? (rem_sh - trial) : rem_sh;
    out_root <= {in_root[W-2:0], fits};
    out_tag  <= in_tag;
  end
endmodule

/* rtl/vn2d_div_cell.sv */
// One step of the paired restoring dividers: one quotient bit for x and for y.
module vn2d_div_cell
  import vn2d_pkg::*;
#(
  parameter int W     = 32,
  parameter bit FIRST = 1'b0,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [W-1:0]     den,
  input  logic [W:0]       in_rem_x,
  input  logic [W:0]       in_rem_y,
  input  logic [QUO_W-1:0] in_quo_x,
  input  logic [QUO_W-1:0] in_quo_y,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [W-1:0]     out_den,
  output logic [W:0]       out_rem_x,
  output logic [W:0]       out_rem_y,
  output logic [QUO_W-1:0] out_quo_x,
  output logic [QUO_W-1:0] out_quo_y,
  output logic [TAG_W-1:0] out_tag
);
  logic [W:0] sh_x, sh_y, den_x;
  logic       ge_x, ge_y;

  always_comb begin
    sh_x  = FIRST ? in_rem_x : {in_rem_x[W-1:0], 1'b0};
    sh_y  = FIRST ? in_rem_y : {in_rem_y[W-1:0], 1'b0};
    den_x = {1'b0, den};
    ge_x  = (sh_x >= den_x);
    ge_y  = (sh_y >= den_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den   <= den;
    out_rem_x <= ge_x ? (sh_x - den_x) : sh_x;
    out_rem_y <= ge_y ? (sh_y - den_x) : sh_y;
    out_quo_x <= {in_quo_x[QUO_W-2:0], ge_x};
    out_quo_y <= {in_quo_y[QUO_W-2:0], ge_y};
    out_tag   <= in_tag;
  end
endmodule

/* rtl/vector_normalize_2d.sv */
// Top level of the 2D vector normalizer: length and unit vector, one word per cycle.
//
//   channel  | handshake            | fields
//   ---------+----------------------+-------------------------------------------
//   input    | start, busy (low)    | x_coord, y_coord
//   result   | done (one cycle)     | magnitude, cosine, sine, zero_vector
//
// Every word passes through the pipeline in order: input register, square, sum,
// one square-root cell per root bit, one divider cell per quotient bit (31),
// output register.
// A new word is taken every cycle; busy stays low.
// Synchronous reset clears only the valid chain; data registers are left alone.
// The receiver cannot stall, so done is a one-cycle strobe.
module vector_normalize_2d
  import vn2d_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] x_coord,
  input  logic [COORD_WIDTH-1:0] y_coord,
  output logic                   done,
  output logic [OUT_W-1:0]       magnitude,
  output logic [OUT_W-1:0]       cosine,
  output logic [OUT_W-1:0]       sine,
  output logic                   zero_vector
);
  localparam int W      = COORD_WIDTH;
  localparam int SQ_TAG = 3 + 2 * W;     // zero, x sign, y sign, |x|, |y|
  localparam int DV_TAG = 3 + W;         // zero, x sign, y sign, length
  localparam int MW     = (W > OUT_W) ? W : OUT_W;

  assign busy = 1'b0;

  // Stage 0: take the word, split off signs.
  logic         s0_valid, s0_xneg, s0_yneg;
  logic [W-1:0] s0_ax, s0_ay;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
    s0_xneg <= x_coord[W-1];
    s0_yneg <= y_coord[W-1];
    s0_ax   <= x_coord[W-1] ? (~x_coord + 1'b1) : x_coord;
    s0_ay   <= y_coord[W-1] ? (~y_coord + 1'b1) : y_coord;
  end

  // Stage 1: square both components.
  logic           s1_valid, s1_xneg, s1_yneg;
  logic [W-1:0]   s1_ax, s1_ay;
  logic [2*W-1:0] s1_sqx, s1_sqy;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_xneg <= s0_xneg;
    s1_yneg <= s0_yneg;
    s1_ax   <= s0_ax;
    s1_ay   <= s0_ay;
    s1_sqx  <= {{W{1'b0}}, s0_ax} * {{W{1'b0}}, s0_ax};
    s1_sqy  <= {{W{1'b0}}, s0_ay} * {{W{1'b0}}, s0_ay};
  end

  // Stage 2: sum of squares (fits, since each square is at most 2^(2W-2)).
  logic              s2_valid;
  logic [2*W-1:0]    s2_sum;
  logic [SQ_TAG-1:0] s2_tag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sum <= s1_sqx + s1_sqy;
    s2_tag <= {(s1_ax == '0) && (s1_ay == '0), s1_xneg, s1_yneg, s1_ax, s1_ay};
  end

  // Square-root chain: cell k retires root bit W-1-k.
  logic              sq_valid [W+1];
  logic [2*W-1:0]    sq_rad   [W+1];
  logic [W+1:0]      sq_rem   [W+1];
  logic [W-1:0]      sq_root  [W+1];
  logic [SQ_TAG-1:0] sq_tag   [W+1];

  assign sq_valid[0] = s2_valid;
  assign sq_rad[0]   = s2_sum;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_tag[0]   = s2_tag;

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    vn2d_sqrt_cell #(.W(W), .TAG_W(SQ_TAG)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[k]),
      .in_rad    (sq_rad[k]),
      .in_rem    (sq_rem[k]),
      .in_root   (sq_root[k]),
      .in_tag    (sq_tag[k]),
      .out_valid (sq_valid[k+1]),
      .out_rad   (sq_rad[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_root  (sq_root[k+1]),
      .out_tag   (sq_tag[k+1])
    );
  end

  // Divider chain: both components over the floored length, MSB of quotient first.
  // A zero vector divides by zero here; the output stage drops that result.
  logic              dv_valid [QUO_W+1];
  logic [W-1:0]      dv_den   [QUO_W+1];
  logic [W:0]        dv_rem_x [QUO_W+1];
  logic [W:0]        dv_rem_y [QUO_W+1];
  logic [QUO_W-1:0]  dv_quo_x [QUO_W+1];
  logic [QUO_W-1:0]  dv_quo_y [QUO_W+1];
  logic [DV_TAG-1:0] dv_tag   [QUO_W+1];
  logic [SQ_TAG-1:0] sq_last;

  assign sq_last     = sq_tag[W];
  assign dv_valid[0] = sq_valid[W];
  assign dv_den[0]   = sq_root[W];
  assign dv_rem_x[0] = {1'b0, sq_last[2*W-1:W]};
  assign dv_rem_y[0] = {1'b0, sq_last[W-1:0]};
  assign dv_quo_x[0] = '0;
  assign dv_quo_y[0] = '0;
  assign dv_tag[0]   = {sq_last[SQ_TAG-1 -: 3], sq_root[W]};

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    vn2d_div_cell #(.W(W), .FIRST(k == 0), .TAG_W(DV_TAG)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[k]),
      .den       (dv_den[k]),
      .in_rem_x  (dv_rem_x[k]),
      .in_rem_y  (dv_rem_y[k]),
      .in_quo_x  (dv_quo_x[k]),
      .in_quo_y  (dv_quo_y[k]),
      .in_tag    (dv_tag[k]),
      .out_valid (dv_valid[k+1]),
      .out_den   (dv_den[k+1]),
      .out_rem_x (dv_rem_x[k+1]),
      .out_rem_y (dv_rem_y[k+1]),
      .out_quo_x (dv_quo_x[k+1]),
      .out_quo_y (dv_quo_y[k+1]),
      .out_tag   (dv_tag[k+1])
    );
  end

  // Output stage: saturate the length, apply signs, force zeros for a zero vector.
  logic [DV_TAG-1:0] fin_tag;
  logic              fin_zero, fin_xneg, fin_yneg, len_sat;
  logic [MW-1:0]     len_ext;
  logic [OUT_W-1:0]  ux, uy;

  always_comb begin
    fin_tag  = dv_tag[QUO_W];
    fin_zero = fin_tag[DV_TAG-1];
    fin_xneg = fin_tag[DV_TAG-2];
    fin_yneg = fin_tag[DV_TAG-3];
    len_ext  = MW'(fin_tag[W-1:0]);
    len_sat  = ((len_ext >> OUT_W) != '0);
    ux       = OUT_W'(dv_quo_x[QUO_W]);
    uy       = OUT_W'(dv_quo_y[QUO_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[QUO_W];
    end
    zero_vector <= fin_zero;
    if (fin_zero) begin
      magnitude <= '0;
      cosine    <= '0;
      sine      <= '0;
    end else begin
      magnitude <= len_sat ? {OUT_W{1'b1}} : len_ext[OUT_W-1:0];
      cosine    <= fin_xneg ? (~ux + 1'b1) : ux;
      sine      <= fin_yneg ? (~uy + 1'b1) : uy;
    end
  end
endmodule
